### src/cda_pkg.sv
// ----------------------------------------------------------------------------
// cda_pkg
// shared widths, limits, month lengths and controller/datapath interfaces
// ----------------------------------------------------------------------------
package cda_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int OFS_W   = 17;

  localparam logic [YEAR_W-1:0]  YEAR_MIN        = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX        = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
  localparam int                 MONTH_PAST_END  = 13;

  // floor(y / 100) as (y * RECIP_100) >> RECIP_SHIFT, exact for 14-bit y
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  localparam logic [DAY_W-1:0] MONTH_LEN [MONTH_PAST_END] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // length of month m, zero for a month code that is not a month
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    len = 5'd0;
    if (m != 4'd0 && m <= MONTHS_PER_YEAR) begin
      len = MONTH_LEN[m];
      if (m == 4'd2 && leap) begin
        len = 5'd29;
      end
    end
    return len;
  endfunction

  typedef struct packed {
    logic load;      // capture a new transaction
    logic init_mod;  // derive year mod 100 and century mod 4
    logic check;     // latch the validity flag
    logic step;      // one month of carry or borrow
  } cda_cmd_t;

  typedef struct packed {
    logic invalid;   // starting date is not a real date
    logic fin;       // current step lands on the final date
  } cda_status_t;

endpackage

### src/calendar_date_add_days_unit.sv
// ----------------------------------------------------------------------------
// calendar_date_add_days_unit
// gregorian date plus a signed day offset, stepped one month per cycle
// ----------------------------------------------------------------------------
// a transaction is taken when start is high and busy is low. the result is
// shown on the result ports for exactly one cycle with done high; the
// receiver cannot stall it, so it must capture the result in that cycle.
// the month-step loop in the datapath, one boundary per cycle, sets how long
// a transaction takes: it walks each month boundary the offset crosses (up
// to about 2200 for the largest offsets). an invalid starting date skips the
// month steps and finishes with the start fields echoed and invalid_input
// set. a result before 0001-01-01 or after 9999-12-31 is clamped to that
// date with year_out_of_range set.
module calendar_date_add_days_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  output logic                             done,
  input  logic [cda_pkg::YEAR_W-1:0]       start_year,
  input  logic [cda_pkg::MONTH_W-1:0]      start_month,
  input  logic [cda_pkg::DAY_W-1:0]        start_day,
  input  logic signed [cda_pkg::OFS_W-1:0] offset_days,
  output logic [cda_pkg::YEAR_W-1:0]       result_year,
  output logic [cda_pkg::MONTH_W-1:0]      result_month,
  output logic [cda_pkg::DAY_W-1:0]        result_day,
  output logic                             year_out_of_range,
  output logic                             invalid_input
);
  import cda_pkg::*;

  // command and status between sequencer and datapath
  cda_cmd_t    cmd;
  cda_status_t status;

  // sequencer: idle, leap setup, validity check, month steps, result cycle
  cda_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // datapath: date registers double as the result registers
  cda_datapath u_datapath (
    .clk               (clk),
    .cmd               (cmd),
    .start_year        (start_year),
    .start_month       (start_month),
    .start_day         (start_day),
    .offset_days       (offset_days),
    .status            (status),
    .result_year       (result_year),
    .result_month      (result_month),
    .result_day        (result_day),
    .year_out_of_range (year_out_of_range),
    .invalid_input     (invalid_input)
  );

endmodule

### src/cda_ctrl.sv
// ----------------------------------------------------------------------------
// cda_ctrl
// sequencer: load, leap setup, validity check, month steps, result strobe
// ----------------------------------------------------------------------------
module cda_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  cda_pkg::cda_status_t status,
  output cda_pkg::cda_cmd_t    cmd,
  output logic                 busy,
  output logic                 done
);
  import cda_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MOD   = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_STEP  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.init_mod = 1'b1;
        state_next   = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = status.invalid ? ST_DONE : ST_STEP;
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        if (status.fin) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

endmodule

### src/cda_datapath.sv
// ----------------------------------------------------------------------------
// cda_datapath
// date registers, remaining offset, leap tracking and one-month step logic
// ----------------------------------------------------------------------------
module cda_datapath (
  input  logic                        clk,
  input  cda_pkg::cda_cmd_t           cmd,
  input  logic [cda_pkg::YEAR_W-1:0]  start_year,
  input  logic [cda_pkg::MONTH_W-1:0] start_month,
  input  logic [cda_pkg::DAY_W-1:0]   start_day,
  input  logic signed [cda_pkg::OFS_W-1:0] offset_days,
  output cda_pkg::cda_status_t        status,
  output logic [cda_pkg::YEAR_W-1:0]  result_year,
  output logic [cda_pkg::MONTH_W-1:0] result_month,
  output logic [cda_pkg::DAY_W-1:0]   result_day,
  output logic                        year_out_of_range,
  output logic                        invalid_input
);
  import cda_pkg::*;

  logic [YEAR_W-1:0]        year, year_next;
  logic [MONTH_W-1:0]       month, month_next;
  logic [DAY_W-1:0]         day, day_next;
  logic signed [OFS_W-1:0]  rem, rem_next;
  logic [7:0]               q100;
  logic [6:0]               ymod100, ymod100_next;
  logic [1:0]               cmod4, cmod4_next;
  logic                     oor, oor_next;
  logic                     inv;

  logic [26:0]              prod;
  logic [14:0]              q_times_100;
  logic [YEAR_W-1:0]        mod_full;
  logic                     leap;
  logic [DAY_W-1:0]         dim;
  logic [DAY_W-1:0]         dim_prev;
  logic [5:0]               gap;
  logic [OFS_W-1:0]         mag;
  logic                     fin;

  assign prod        = {13'd0, start_year} * {14'd0, RECIP_100};
  assign q_times_100 = {7'd0, q100} * 15'd100;
  assign mod_full    = year - q_times_100[YEAR_W-1:0];

  assign leap = ((year[1:0] == 2'd0) && (ymod100 != 7'd0)) ||
                ((ymod100 == 7'd0) && (cmod4 == 2'd0));
  assign dim  = month_days(month, leap);
  // month before the current one; december is always 31 days
  assign dim_prev = (month == 4'd1) ? 5'd31 : month_days(month - 4'd1, leap);
  assign gap  = {1'b0, dim} - {1'b0, day} + 6'd1;
  assign mag  = -rem;

  assign status.invalid = (year < YEAR_MIN) || (year > YEAR_MAX) ||
                          (month == 4'd0) || (month > MONTHS_PER_YEAR) ||
                          (day == 5'd0) || (day > dim);

  always_comb begin
    year_next    = year;
    month_next   = month;
    day_next     = day;
    rem_next     = rem;
    ymod100_next = ymod100;
    cmod4_next   = cmod4;
    oor_next     = oor;
    fin          = 1'b0;
    priority if (rem == '0) begin
      fin = 1'b1;
    end else if (!rem[OFS_W-1]) begin
      // forward: jump to the first of next month or land inside this one
      if (rem >= $signed({{(OFS_W-6){1'b0}}, gap})) begin
        if (month == MONTHS_PER_YEAR && year == YEAR_MAX) begin
          day_next = 5'd31;
          oor_next = 1'b1;
          rem_next = '0;
          fin      = 1'b1;
        end else begin
          rem_next = rem - $signed({{(OFS_W-6){1'b0}}, gap});
          day_next = 5'd1;
          if (month == MONTHS_PER_YEAR) begin
            month_next = 4'd1;
            year_next  = year + 14'd1;
            if (ymod100 == 7'd99) begin
              ymod100_next = 7'd0;
              cmod4_next   = cmod4 + 2'd1;
            end else begin
              ymod100_next = ymod100 + 7'd1;
            end
          end else begin
            month_next = month + 4'd1;
          end
        end
      end else begin
        day_next = day + rem[DAY_W-1:0];
        rem_next = '0;
        fin      = 1'b1;
      end
    end else begin
      // backward: drop to the last day of the previous month or land here
      if (mag >= {{(OFS_W-DAY_W){1'b0}}, day}) begin
        if (month == 4'd1 && year == YEAR_MIN) begin
          day_next = 5'd1;
          oor_next = 1'b1;
          rem_next = '0;
          fin      = 1'b1;
        end else begin
          rem_next = rem + $signed({{(OFS_W-DAY_W){1'b0}}, day});
          day_next = dim_prev;
          if (month == 4'd1) begin
            month_next = MONTHS_PER_YEAR;
            year_next  = year - 14'd1;
            if (ymod100 == 7'd0) begin
              ymod100_next = 7'd99;
              cmod4_next   = cmod4 - 2'd1;
            end else begin
              ymod100_next = ymod100 - 7'd1;
            end
          end else begin
            month_next = month - 4'd1;
          end
        end
      end else begin
        day_next = day - mag[DAY_W-1:0];
        rem_next = '0;
        fin      = 1'b1;
      end
    end
  end

  assign status.fin = fin;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year  <= start_year;
      month <= start_month;
      day   <= start_day;
      rem   <= offset_days;
      q100  <= prod[RECIP_SHIFT+7:RECIP_SHIFT];
      oor   <= 1'b0;
      inv   <= 1'b0;
    end else if (cmd.init_mod) begin
      ymod100 <= mod_full[6:0];
      cmod4   <= q100[1:0];
    end else if (cmd.check) begin
      inv <= status.invalid;
    end else if (cmd.step) begin
      year    <= year_next;
      month   <= month_next;
      day     <= day_next;
      rem     <= rem_next;
      ymod100 <= ymod100_next;
      cmod4   <= cmod4_next;
      oor     <= oor_next;
    end
  end

  assign result_year       = year;
  assign result_month      = month;
  assign result_day        = day;
  assign year_out_of_range = oor;
  assign invalid_input     = inv;

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks calendar_date_add_days_unit against a day-count model of the
// gregorian calendar: directed corner dates first, then random dates and
// offsets with random gaps on the command side
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cda_pkg::*;

  localparam int RANDOM_ITEMS = 236;
  localparam int MAX_GAP      = 12;

  // one command: a starting date and a signed day offset
  typedef struct {
    logic [YEAR_W-1:0]       year;
    logic [MONTH_W-1:0]      month;
    logic [DAY_W-1:0]        day;
    logic signed [OFS_W-1:0] offset;
    bit                      drain_first;  // hold off until all dates are back
    bit                      calm;         // no gap in front of this one
  } date_cmd_t;

  // one shifted date as the unit should report it
  typedef struct {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               clamped;
    logic               bad_date;
  } shifted_date_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    done;
  logic [YEAR_W-1:0]       start_year = '0;
  logic [MONTH_W-1:0]      start_month = '0;
  logic [DAY_W-1:0]        start_day = '0;
  logic signed [OFS_W-1:0] offset_days = '0;
  logic [YEAR_W-1:0]       result_year;
  logic [MONTH_W-1:0]      result_month;
  logic [DAY_W-1:0]        result_day;
  logic                    year_out_of_range;
  logic                    invalid_input;

  date_cmd_t     pending_cmds[$];
  shifted_date_t shifted_dates[$];
  date_cmd_t     cur_cmd;
  int            errors = 0;
  int            gap_left = 0;
  bit            gap_rolled = 1'b0;
  bit            sending;

  calendar_date_add_days_unit uut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .done              (done),
    .start_year        (start_year),
    .start_month       (start_month),
    .start_day         (start_day),
    .offset_days       (offset_days),
    .result_year       (result_year),
    .result_month      (result_month),
    .result_day        (result_day),
    .year_out_of_range (year_out_of_range),
    .invalid_input     (invalid_input)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // reset held from the start and released once
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------- calendar

  // divisible by 4, except centuries not divisible by 400
  function automatic bit leap_year(int y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int days_of_month(int y, int m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // count of days from a fixed origin; the year is taken to start in march
  // so that the leap day falls at its end
  function automatic longint day_count(int y, int m, int d);
    longint yr, cycle400, yr_in_cycle, mon_idx, day_in_yr;
    yr          = y - ((m <= 2) ? 1 : 0);
    cycle400    = yr / 400;
    yr_in_cycle = yr - cycle400 * 400;
    mon_idx     = (m > 2) ? m - 3 : m + 9;
    day_in_yr   = (153 * mon_idx + 2) / 5 + d - 1;
    return cycle400 * 146097 + yr_in_cycle * 365 + yr_in_cycle / 4
           - yr_in_cycle / 100 + day_in_yr;
  endfunction

  // inverse of day_count for a non-negative count
  function automatic void date_of_count(longint n, output int y, output int m,
                                        output int d);
    longint cycle400, day_in_cycle, yr_in_cycle, day_in_yr, mon_idx;
    cycle400     = n / 146097;
    day_in_cycle = n - cycle400 * 146097;
    yr_in_cycle  = (day_in_cycle - day_in_cycle / 1460 + day_in_cycle / 36524
                    - day_in_cycle / 146096) / 365;
    day_in_yr    = day_in_cycle - (365 * yr_in_cycle + yr_in_cycle / 4
                                   - yr_in_cycle / 100);
    mon_idx      = (5 * day_in_yr + 2) / 153;
    d = int'(day_in_yr - (153 * mon_idx + 2) / 5 + 1);
    m = int'((mon_idx < 10) ? mon_idx + 3 : mon_idx - 9);
    y = int'(yr_in_cycle + cycle400 * 400 + ((m <= 2) ? 1 : 0));
  endfunction

  // the date the unit should report for one command
  function automatic shifted_date_t shift_date(date_cmd_t c);
    shifted_date_t r;
    int     y, m, d, ry, rm, rd, ofs;
    longint n, first_day, last_day;
    y   = c.year;
    m   = c.month;
    d   = c.day;
    ofs = int'(c.offset);
    r.clamped  = 1'b0;
    r.bad_date = 1'b0;
    // not a real date: fields echoed, only the invalid flag raised
    if (y < int'(YEAR_MIN) || y > int'(YEAR_MAX) || m < 1 ||
        m > int'(MONTHS_PER_YEAR) || d < 1 || d > days_of_month(y, m)) begin
      r.year     = c.year;
      r.month    = c.month;
      r.day      = c.day;
      r.bad_date = 1'b1;
      return r;
    end
    first_day = day_count(int'(YEAR_MIN), 1, 1);
    last_day  = day_count(int'(YEAR_MAX), 12, 31);
    n = day_count(y, m, d) + ofs;
    // outside years 1..9999 the date sticks to the nearest end
    if (n < first_day) begin
      n = first_day;
      r.clamped = 1'b1;
    end else if (n > last_day) begin
      n = last_day;
      r.clamped = 1'b1;
    end
    date_of_count(n, ry, rm, rd);
    r.year  = YEAR_W'(ry);
    r.month = MONTH_W'(rm);
    r.day   = DAY_W'(rd);
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void queue_date(int y, int m, int d, int ofs);
    date_cmd_t c;
    c.year        = YEAR_W'(y);
    c.month       = MONTH_W'(m);
    c.day         = DAY_W'(d);
    c.offset      = OFS_W'(ofs);
    c.drain_first = 1'b0;
    c.calm        = 1'b0;
    pending_cmds.push_back(c);
  endfunction

  initial begin
    date_cmd_t c;
    int y, m, d, ofs, pick;

    // leap day handling, including the century rule
    queue_date(2000, 2, 29, 0);
    queue_date(1900, 2, 29, 1);        // no leap day in a plain century
    queue_date(2000, 2, 28, 1);
    queue_date(1900, 2, 28, 1);
    queue_date(2024, 3, 1, -1);
    // year ends, both directions
    queue_date(2023, 12, 31, 1);
    queue_date(2024, 1, 1, -1);
    // clamping at the two ends of the calendar
    queue_date(1, 1, 1, -1);
    queue_date(1, 1, 2, -1);
    queue_date(1, 1, 2, -2);
    queue_date(9999, 12, 31, 1);
    queue_date(9999, 1, 1, 364);
    queue_date(9999, 1, 1, 365);
    queue_date(1, 1, 1, 65535);
    queue_date(9999, 12, 31, -65536);
    // largest offsets without clamping: the longest month walks
    queue_date(5000, 6, 15, 65535);
    queue_date(5000, 6, 15, -65536);
    // dates that do not exist, and a last one that does
    queue_date(0, 1, 1, 5);
    queue_date(16383, 15, 31, -1);
    queue_date(2021, 0, 10, 3);
    queue_date(2021, 13, 10, 3);
    queue_date(2021, 5, 0, 3);
    queue_date(2021, 4, 31, 3);
    queue_date(2021, 1, 31, 31);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 99) < 18) begin
        // raw field values, mostly dates that do not exist
        c.year   = YEAR_W'($urandom);
        c.month  = MONTH_W'($urandom);
        c.day    = DAY_W'($urandom);
        c.offset = OFS_W'($urandom);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          y = $urandom_range(1, 3);
        end else if (pick == 1) begin
          y = $urandom_range(9997, 9999);
        end else begin
          y = $urandom_range(1, 9999);
        end
        m = $urandom_range(1, 12);
        d = $urandom_range(1, days_of_month(y, m));
        pick = $urandom_range(0, 99);
        // mostly short walks; full range offsets keep the unit busy for long
        if (pick < 70) begin
          ofs = int'($urandom_range(0, 4000)) - 2000;
        end else if (pick < 85) begin
          ofs = int'($urandom_range(0, 131071)) - 65536;
        end else begin
          ofs = int'($urandom_range(0, 800)) - 400;
        end
        c.year   = YEAR_W'(y);
        c.month  = MONTH_W'(m);
        c.day    = DAY_W'(d);
        c.offset = OFS_W'(ofs);
      end
      c.drain_first = (i == 0) || (i == 200);
      c.calm        = (i >= 100) && (i < 160);
      pending_cmds.push_back(c);
    end
  end

  // ---------------------------------------------------------------- driver

  // start stays high until the unit takes the transaction; the next one is
  // launched right away, after a random gap or, if marked, once all dates are back
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      sending = start;
      if (start && !busy) begin
        shifted_dates.push_back(shift_date(cur_cmd));
        sending = 1'b0;
      end
      if (!sending && pending_cmds.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds[0].drain_first && shifted_dates.size() > 0) begin
          // wait for the unit to drain completely
        end else if (!gap_rolled && !pending_cmds[0].calm &&
                     $urandom_range(0, 99) < 35) begin
          gap_rolled = 1'b1;
          gap_left   = $urandom_range(0, MAX_GAP - 1);
        end else begin
          gap_rolled = 1'b0;
          cur_cmd    = pending_cmds.pop_front();
          sending    = 1'b1;
          start_year  <= cur_cmd.year;
          start_month <= cur_cmd.month;
          start_day   <= cur_cmd.day;
          offset_days <= cur_cmd.offset;
        end
      end
      start <= sending;
    end
  end

  // ---------------------------------------------------------------- monitor

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // done marks a single cycle; the result has to be taken right then
  always @(posedge clk) begin
    shifted_date_t want;
    if (!rst && done) begin
      if (shifted_dates.size() == 0) begin
        $display("%0t: result with no transaction outstanding, actual %0d-%0d-%0d",
                 $time, result_year, result_month, result_day);
        errors++;
      end else begin
        want = shifted_dates.pop_front();
        check_field("result_year", want.year, result_year);
        check_field("result_month", want.month, result_month);
        check_field("result_day", want.day, result_day);
        check_field("year_out_of_range", want.clamped, year_out_of_range);
        check_field("invalid_input", want.bad_date, invalid_input);
      end
    end
  end

  // ---------------------------------------------------------------- end of run

  // sampled on the falling edge, after the driver and monitor have settled
  initial begin
    @(negedge rst);
    while (pending_cmds.size() > 0 || start || shifted_dates.size() > 0) begin
      @(negedge clk);
    end
    // room for a stray result after the last one
    repeat (20) @(posedge clk);
    if (shifted_dates.size() != 0) begin
      errors++;
    end
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // worst case is every transaction walking the full offset range
  initial begin
    #30_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

### filelist.f
src/cda_pkg.sv
src/cda_ctrl.sv
src/cda_datapath.sv
src/calendar_date_add_days_unit.sv
tb/tb.sv
